>>> hw/rtl/vmdp_pkg.sv
// Shared types and codes for the variant metadata dictionary parser.
package vmdp_pkg;

	// parse phase
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DICT = 2'd1;
	localparam logic [1:0] PH_OFFS = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_STRING = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_EMPTY     = 3'd1;
	localparam logic [2:0] ERR_VERSION   = 3'd2;
	localparam logic [2:0] ERR_TRUNCATED = 3'd3;
	localparam logic [2:0] ERR_OVERRUN   = 3'd4;
	localparam logic [2:0] ERR_DECREASE  = 3'd5;

	localparam logic [3:0] HDR_VERSION = 4'd1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] entry_index;
		logic [31:0] string_start;
		logic [31:0] string_length;
		logic [31:0] total_bytes;
		logic        sorted;
		logic [2:0]  error_code;
	} result_t;

endpackage

>>> hw/rtl/variant_metadata_dictionary_parser.sv
// Top level of the variant metadata dictionary parser: input register, step logic, result register.
//
// Takes a variant metadata buffer one byte per item (first_byte marks the header byte and
// samples buffer_size) and reports each dictionary string as a start position and length,
// then a completion item with the total size; errors end the buffer with an error item.
// The last string of a dictionary is reported inside the completion item. Bytes after the
// offsets, and any byte outside a buffer, produce no result. Rate: one byte per cycle,
// sustained while no result waits on out_stall; each byte is held in the input register
// and its result, if any, is registered in the result register, where out_valid marks it.
// Throughput is set by the single step stage that updates the parser state once for each
// byte it takes; it drops only while out_stall holds a waiting result.
module variant_metadata_dictionary_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic [31:0] buffer_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [31:0] entry_index,
	output logic [31:0] string_start,
	output logic [31:0] string_length,
	output logic [31:0] total_bytes,
	output logic        strings_sorted,
	output logic [2:0]  error_code
);

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic [31:0] size_s1;

	// result register
	logic              out_valid_q;
	vmdp_pkg::result_t res_q;

	logic              adv;
	logic              fire;
	logic              accept;
	logic              res_valid;
	vmdp_pkg::result_t res;

	// the step stage moves whenever the result register is free or being drained
	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			size_s1  <= buffer_size;
		end
	end

	vmdp_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (data_s1),
		.first_byte  (first_s1),
		.buffer_size (size_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = res_q.kind;
	assign entry_index    = res_q.entry_index;
	assign string_start   = res_q.string_start;
	assign string_length  = res_q.string_length;
	assign total_bytes    = res_q.total_bytes;
	assign strings_sorted = res_q.sorted;
	assign error_code     = res_q.error_code;

endmodule

>>> hw/rtl/vmdp_step.sv
// Parser state and the per-byte step logic.
module vmdp_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            data_byte,
	input  logic                  first_byte,
	input  logic [31:0]           buffer_size,
	output logic                  res_valid,
	output vmdp_pkg::result_t     res
);

	logic [1:0]  phase_q,  phase_n;
	logic [2:0]  ow_q,     ow_n;
	logic [1:0]  cnt_q,    cnt_n;
	logic [31:0] acc_q,    acc_n;
	logic [31:0] dc_q,     dc_n;
	logic [31:0] sc_q,     sc_n;
	logic [31:0] prev_q,   prev_n;
	logic [32:0] bp_q,     bp_n;
	logic [31:0] cap_q,    cap_n;
	logic [34:0] base_q,   base_n;
	logic        sf_q,     sf_n;

	logic [31:0] acc_new;
	logic [32:0] bp_inc;
	logic [32:0] val_p1;
	logic [34:0] mul;
	logic [33:0] total;
	logic [35:0] str_end;
	logic        fits;
	logic        hdr_fits;
	logic [31:0] value;

	always_comb begin
		acc_new  = acc_q | ({24'd0, data_byte} << {cnt_q, 3'b000});
		bp_inc   = bp_q + 33'd1;
		value    = acc_new;
		val_p1   = {1'b0, value} + 33'd1;
		// (value + 1) * offset width, width is 1..4
		case (ow_q)
			3'd2:    mul = {1'b0, val_p1, 1'b0};
			3'd3:    mul = {2'b00, val_p1} + {1'b0, val_p1, 1'b0};
			3'd4:    mul = {val_p1, 2'b00};
			default: mul = {2'b00, val_p1};
		endcase
		fits     = ({1'b0, bp_inc} + {31'd0, ow_q}) <= {2'b00, cap_q};
		hdr_fits = ({31'd0, {1'b0, data_byte[7:6]}} + 34'd2) <= {2'b00, buffer_size};
		total    = {1'b0, bp_inc} + {2'b00, value};
		str_end  = {1'b0, base_q} + {4'd0, value};
	end

	always_comb begin
		phase_n   = phase_q;
		ow_n      = ow_q;
		cnt_n     = cnt_q;
		acc_n     = acc_q;
		dc_n      = dc_q;
		sc_n      = sc_q;
		prev_n    = prev_q;
		bp_n      = bp_q;
		cap_n     = cap_q;
		base_n    = base_q;
		sf_n      = sf_q;
		res_valid = 1'b0;
		res       = '0;

		if (first_byte) begin
			phase_n = vmdp_pkg::PH_IDLE;
			ow_n    = 3'd1;
			cnt_n   = '0;
			acc_n   = '0;
			dc_n    = '0;
			sc_n    = '0;
			prev_n  = '0;
			bp_n    = '0;
			cap_n   = buffer_size;
			base_n  = '0;
			sf_n    = 1'b0;
			if (buffer_size == 32'd0) begin
				res_valid      = 1'b1;
				res.kind       = vmdp_pkg::KIND_ERROR;
				res.error_code = vmdp_pkg::ERR_EMPTY;
			end else begin
				sf_n = data_byte[4];
				ow_n = {1'b0, data_byte[7:6]} + 3'd1;
				bp_n = 33'd1;
				if (data_byte[3:0] != vmdp_pkg::HDR_VERSION) begin
					res_valid      = 1'b1;
					res.kind       = vmdp_pkg::KIND_ERROR;
					res.error_code = vmdp_pkg::ERR_VERSION;
				end else if (!hdr_fits) begin
					res_valid      = 1'b1;
					res.kind       = vmdp_pkg::KIND_ERROR;
					res.error_code = vmdp_pkg::ERR_TRUNCATED;
				end else begin
					phase_n = vmdp_pkg::PH_DICT;
				end
			end
		end else if (phase_q != vmdp_pkg::PH_IDLE) begin
			bp_n = bp_inc;
			if (({1'b0, cnt_q} + 3'd1) < ow_q) begin
				cnt_n = cnt_q + 2'd1;
				acc_n = acc_new;
			end else begin
				acc_n = '0;
				cnt_n = '0;
				if (phase_q == vmdp_pkg::PH_DICT) begin
					dc_n   = value;
					base_n = {2'b00, bp_inc} + mul;
					sc_n   = '0;
					if (!fits) begin
						res_valid      = 1'b1;
						res.kind       = vmdp_pkg::KIND_ERROR;
						res.error_code = vmdp_pkg::ERR_TRUNCATED;
					end else begin
						phase_n = vmdp_pkg::PH_OFFS;
					end
				end else if (sc_q == 32'd0) begin
					prev_n = value;
					sc_n   = 32'd1;
					if (dc_q == 32'd0) begin
						// empty dictionary: total saturates, no end check
						res_valid        = 1'b1;
						res.kind         = vmdp_pkg::KIND_DONE;
						res.string_start = base_q[31:0];
						res.total_bytes  = (total[33:32] != 2'b00) ? 32'hFFFF_FFFF
							: total[31:0];
					end else if (!fits) begin
						res_valid      = 1'b1;
						res.kind       = vmdp_pkg::KIND_ERROR;
						res.error_code = vmdp_pkg::ERR_TRUNCATED;
					end
				end else if (value < prev_q) begin
					res_valid      = 1'b1;
					res.kind       = vmdp_pkg::KIND_ERROR;
					res.error_code = vmdp_pkg::ERR_DECREASE;
				end else if (str_end > {4'd0, cap_q}) begin
					res_valid      = 1'b1;
					res.kind       = vmdp_pkg::KIND_ERROR;
					res.error_code = vmdp_pkg::ERR_OVERRUN;
				end else begin
					res.entry_index   = sc_q - 32'd1;
					res.string_start  = base_q[31:0] + prev_q;
					res.string_length = value - prev_q;
					if (sc_q == dc_q) begin
						// last offset closes the final string and the dictionary
						res_valid       = 1'b1;
						res.kind        = vmdp_pkg::KIND_DONE;
						res.total_bytes = total[31:0];
					end else begin
						prev_n = value;
						sc_n   = sc_q + 32'd1;
						res_valid = 1'b1;
						if (!fits) begin
							res            = '0;
							res.kind       = vmdp_pkg::KIND_ERROR;
							res.error_code = vmdp_pkg::ERR_TRUNCATED;
						end else begin
							res.kind = vmdp_pkg::KIND_STRING;
						end
					end
				end
			end
		end
		if (res_valid) begin
			if (res.kind != vmdp_pkg::KIND_STRING || res.error_code != vmdp_pkg::ERR_NONE) begin
				phase_n = vmdp_pkg::PH_IDLE;
			end
		end
		res.sorted = sf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vmdp_pkg::PH_IDLE;
			ow_q    <= 3'd1;
			cnt_q   <= '0;
			acc_q   <= '0;
			dc_q    <= '0;
			sc_q    <= '0;
			prev_q  <= '0;
			bp_q    <= '0;
			cap_q   <= '0;
			base_q  <= '0;
			sf_q    <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			ow_q    <= ow_n;
			cnt_q   <= cnt_n;
			acc_q   <= acc_n;
			dc_q    <= dc_n;
			sc_q    <= sc_n;
			prev_q  <= prev_n;
			bp_q    <= bp_n;
			cap_q   <= cap_n;
			base_q  <= base_n;
			sf_q    <= sf_n;
		end
	end

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == vmdp_pkg::PH_IDLE |-> (acc_q == 32'd0 && cnt_q == 2'd0))
		else $error("idle with partial field");

	a_cnt_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} < ow_q) && ow_q != 3'd0 && ow_q <= 3'd4)
		else $error("field byte count out of offset width");

	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && first_byte && buffer_size == 32'd0 |=> phase_q == vmdp_pkg::PH_IDLE)
		else $error("empty buffer did not return to idle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == vmdp_pkg::KIND_ERROR |->
		(res.entry_index == 32'd0 && res.string_length == 32'd0 &&
		 res.total_bytes == 32'd0 && res.error_code != vmdp_pkg::ERR_NONE))
		else $error("error result carries payload");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for the variant metadata dictionary parser.
`timescale 1ns / 1ps

module tb;

	// one input item: a buffer byte plus its header mark and the size sampled with it
	typedef struct packed {
		logic [7:0]  data;
		logic        hdr;
		logic [31:0] cap;
	} meta_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        first_byte = 1'b0;
	logic [31:0] buffer_size = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [31:0] entry_index;
	logic [31:0] string_start;
	logic [31:0] string_length;
	logic [31:0] total_bytes;
	logic        strings_sorted;
	logic [2:0]  error_code;

	variant_metadata_dictionary_parser DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.buffer_size    (buffer_size),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.entry_index    (entry_index),
		.string_start   (string_start),
		.string_length  (string_length),
		.total_bytes    (total_bytes),
		.strings_sorted (strings_sorted),
		.error_code     (error_code)
	);

	always #2 clk = ~clk;

	// stimulus and scoreboard storage
	meta_byte_t        byte_stream[$];
	vmdp_pkg::result_t awaited_results[$];
	meta_byte_t        next_item;
	vmdp_pkg::result_t want, predicted;
	bit          item_taken = 1'b0;
	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_cycles = 0;
	int unsigned queued_bytes = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;

	// parser state mirror; initial values are the reset state
	logic [1:0]  parse_phase = vmdp_pkg::PH_IDLE;
	logic [2:0]  width_bytes = 3'd1;
	int unsigned field_bytes = 0;
	logic [31:0] field_value = 32'd0;
	logic [31:0] dict_entries = 32'd0;
	logic [31:0] offsets_seen = 32'd0;
	logic [31:0] prior_offset = 32'd0;
	logic [63:0] byte_pos = 64'd0;   // 33 bits wide in hardware
	logic [31:0] buf_cap = 32'd0;
	logic [63:0] area_start = 64'd0; // first byte of the string area
	logic        hdr_sorted = 1'b0;

	task automatic log_failure(input string msg);
		$display("[%0t] ERROR %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp_v);
		if (got !== exp_v)
			log_failure($sformatf("result %0d: %s = 0x%0h, expected 0x%0h",
				results_seen, name, got, exp_v));
	endtask

	// next offset or size field fits inside the declared buffer
	function automatic bit room_for_field();
		return byte_pos + width_bytes <= buf_cap;
	endfunction

	function automatic void flag_error(input logic [2:0] code, output vmdp_pkg::result_t r);
		parse_phase = vmdp_pkg::PH_IDLE;
		r = '0;
		r.kind = vmdp_pkg::KIND_ERROR;
		r.error_code = code;
		r.sorted = hdr_sorted;
	endfunction

	// Advance the parser mirror by one byte; returns 1 when the byte yields a result.
	function automatic bit parse_byte(input logic [7:0] b, input logic hdr, input logic [31:0] cap,
			output vmdp_pkg::result_t r);
		logic [31:0] value;
		logic [63:0] wide;
		r = '0;
		if (hdr) begin
			// a header always restarts from scratch
			parse_phase = vmdp_pkg::PH_IDLE;
			width_bytes = 3'd1;
			field_bytes = 0;
			field_value = 32'd0;
			dict_entries = 32'd0;
			offsets_seen = 32'd0;
			prior_offset = 32'd0;
			byte_pos = 64'd0;
			area_start = 64'd0;
			hdr_sorted = 1'b0;
			buf_cap = cap;
			if (cap == 32'd0) begin
				flag_error(vmdp_pkg::ERR_EMPTY, r);
				return 1'b1;
			end
			hdr_sorted = b[4];
			width_bytes = {1'b0, b[7:6]} + 3'd1;
			byte_pos = 64'd1;
			if (b[3:0] != vmdp_pkg::HDR_VERSION) begin
				flag_error(vmdp_pkg::ERR_VERSION, r);
				return 1'b1;
			end
			if (!room_for_field()) begin
				flag_error(vmdp_pkg::ERR_TRUNCATED, r);
				return 1'b1;
			end
			parse_phase = vmdp_pkg::PH_DICT;
			return 1'b0;
		end
		if (parse_phase == vmdp_pkg::PH_IDLE)
			return 1'b0;

		// little-endian field assembly
		field_value = field_value | (32'(b) << (8 * field_bytes));
		byte_pos = (byte_pos + 64'd1) & 64'h1_FFFF_FFFF;
		if (field_bytes + 1 < width_bytes) begin
			field_bytes++;
			return 1'b0;
		end
		value = field_value;
		field_value = 32'd0;
		field_bytes = 0;

		if (parse_phase == vmdp_pkg::PH_DICT) begin
			dict_entries = value;
			area_start = byte_pos + (64'(value) + 64'd1) * width_bytes;
			offsets_seen = 32'd0;
			if (!room_for_field()) begin
				flag_error(vmdp_pkg::ERR_TRUNCATED, r);
				return 1'b1;
			end
			parse_phase = vmdp_pkg::PH_OFFS;
			return 1'b0;
		end

		// offset list
		if (offsets_seen == 32'd0) begin
			prior_offset = value;
			offsets_seen = 32'd1;
			if (dict_entries == 32'd0) begin
				// empty dictionary: total saturates, no overrun check
				wide = byte_pos + value;
				if (wide > 64'hFFFF_FFFF)
					wide = 64'hFFFF_FFFF;
				parse_phase = vmdp_pkg::PH_IDLE;
				r.kind = vmdp_pkg::KIND_DONE;
				r.string_start = area_start[31:0];
				r.total_bytes = wide[31:0];
				r.sorted = hdr_sorted;
				return 1'b1;
			end
			if (!room_for_field()) begin
				flag_error(vmdp_pkg::ERR_TRUNCATED, r);
				return 1'b1;
			end
			return 1'b0;
		end

		// decreasing offsets win over overrun
		if (value < prior_offset) begin
			flag_error(vmdp_pkg::ERR_DECREASE, r);
			return 1'b1;
		end
		if (area_start + value > buf_cap) begin
			flag_error(vmdp_pkg::ERR_OVERRUN, r);
			return 1'b1;
		end
		wide = area_start + prior_offset;
		r.entry_index = offsets_seen - 32'd1;
		r.string_start = wide[31:0];
		r.string_length = value - prior_offset;
		r.sorted = hdr_sorted;
		if (offsets_seen == dict_entries) begin
			// last string rides in the completion item
			wide = byte_pos + value;
			parse_phase = vmdp_pkg::PH_IDLE;
			r.kind = vmdp_pkg::KIND_DONE;
			r.total_bytes = wide[31:0];
			return 1'b1;
		end
		prior_offset = value;
		offsets_seen = offsets_seen + 32'd1;
		if (!room_for_field()) begin
			flag_error(vmdp_pkg::ERR_TRUNCATED, r);
			return 1'b1;
		end
		r.kind = vmdp_pkg::KIND_STRING;
		return 1'b1;
	endfunction

	task automatic push_byte(input logic [7:0] data, input logic hdr, input logic [31:0] cap);
		byte_stream.push_back('{data: data, hdr: hdr, cap: cap});
		queued_bytes++;
	endtask

	task automatic push_field(input logic [31:0] value, input int unsigned width);
		for (int k = 0; k < width; k++)
			push_byte(8'(value >> (8 * k)), 1'b0, $urandom());
	endtask

	// One metadata buffer: mostly well formed, sometimes broken on purpose.
	task automatic queue_random_dictionary();
		logic [1:0]      wcode;
		logic [3:0]      version;
		logic [31:0]     cap;
		logic [31:0]     declared;
		logic [7:0]      body[$];
		longint unsigned offs[$];
		longint unsigned span_max, step, total;
		int unsigned     width, entries, fault, cut, n;
		wcode    = 2'($urandom_range(3, 0));
		width    = wcode + 1;
		span_max = (64'd1 << (8 * width)) - 1;
		entries  = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 0);
		fault    = $urandom_range(11, 0);

		offs.push_back(($urandom_range(5, 0) == 0) ? (longint'($urandom()) & span_max) : 0);
		for (int i = 0; i < entries; i++) begin
			step = ($urandom_range(4, 0) == 0) ? (longint'($urandom()) & span_max)
				: longint'($urandom_range(6, 0));
			if (offs[i] + step > span_max)
				step = 0;
			offs.push_back(offs[i] + step);
		end
		// one offset stepping back
		if (fault == 1 && entries > 0) begin
			cut = $urandom_range(entries, 1);
			if (offs[cut - 1] == 0)
				offs[cut - 1] = 1;
			offs[cut] = offs[cut - 1] - 1;
		end

		total = 1 + width * (entries + 2) + offs[entries];
		cap = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(total);
		case (fault)
			3: cap = cap - $urandom_range(3, 1);  // a little short
			4: cap = $urandom();
			default: if (cap < 32'hFFFF_FFF0) cap = cap + $urandom_range(2, 0);
		endcase

		version = vmdp_pkg::HDR_VERSION;
		if (fault == 0) begin
			version = 4'($urandom_range(15, 0));
			if (version == vmdp_pkg::HDR_VERSION)
				version = 4'd0;
		end
		// count field disagreeing with the offsets that follow
		declared = (fault == 5) ? 32'($urandom() & span_max) : entries;

		for (int k = 0; k < width; k++)
			body.push_back(8'(declared >> (8 * k)));
		foreach (offs[i])
			for (int k = 0; k < width; k++)
				body.push_back(8'(offs[i] >> (8 * k)));

		push_byte({wcode, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), version},
			1'b1, cap);
		n = (fault == 2) ? $urandom_range(body.size() - 1, 0) : body.size();
		for (int i = 0; i < n; i++)
			push_byte(body[i], 1'b0, $urandom());
		// string bytes are skipped by the block
		if (fault != 2)
			repeat ($urandom_range(4, 0))
				push_byte(8'($urandom()), 1'b0, $urandom());
	endtask

	task automatic wait_for_drain();
		do @(posedge clk);
		while (byte_stream.size() != 0 || in_valid || awaited_results.size() != 0);
	endtask

	// Driver: new item only once the current one is taken; changes at the falling edge.
	always @(negedge clk) begin
		if (!in_valid || item_taken) begin
			if (arst_n && byte_stream.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
				next_item = byte_stream.pop_front();
				in_valid    <= 1'b1;
				data_byte   <= next_item.data;
				first_byte  <= next_item.hdr;
				buffer_size <= next_item.cap;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure: a forced hold-off stretch, else random stalls.
	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			out_stall   <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	// Monitor: check delivered results first, then predict for the byte taken at this edge.
	always @(posedge clk) begin
		item_taken = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					log_failure($sformatf("result %0d: unexpected, kind %0d error %0d",
						results_seen, result_kind, error_code));
				end else begin
					want = awaited_results.pop_front();
					check_field("result_kind", 32'(result_kind), 32'(want.kind));
					check_field("entry_index", entry_index, want.entry_index);
					check_field("string_start", string_start, want.string_start);
					check_field("string_length", string_length, want.string_length);
					check_field("total_bytes", total_bytes, want.total_bytes);
					check_field("strings_sorted", 32'(strings_sorted), 32'(want.sorted));
					check_field("error_code", 32'(error_code), 32'(want.error_code));
				end
				results_seen++;
			end
			if (in_valid && !in_stall) begin
				item_taken = 1'b1;
				if (parse_byte(data_byte, first_byte, buffer_size, predicted))
					awaited_results.push_back(predicted);
			end
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed corner cases, no idling
		push_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);     // stray byte before any header
		push_byte(8'h01, 1'b1, 32'd0);             // empty buffer
		push_byte(8'hF2, 1'b1, 32'd100);           // bad version, flag set, width 4
		push_byte(8'hC1, 1'b1, 32'd4);             // width 4 cannot fit the size field
		push_byte(8'h01, 1'b1, 32'd2);             // size read leaves no room for offsets
		push_field(32'd0, 1);
		push_byte(8'hD1, 1'b1, 32'hFFFF_FFFF);     // empty dictionary, total saturates
		push_field(32'd0, 4);
		push_field(32'hFFFF_FFFF, 4);
		push_byte(8'h11, 1'b1, 32'd10);            // one string, then offsets go down
		push_field(32'd2, 1);
		push_field(32'd0, 1);
		push_field(32'd3, 1);
		push_field(32'd1, 1);
		push_byte(8'h01, 1'b1, 32'd6);             // string ends past the buffer
		push_field(32'd1, 1);
		push_field(32'd0, 1);
		push_field(32'd5, 1);
		push_byte(8'h51, 1'b1, 32'd5);             // second offset read would not fit
		push_field(32'd1, 2);
		push_field(32'd0, 2);
		wait_for_drain();

		// random phases; each drain doubles as a sender pause
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
					hold_cycles = 400;  // long hold-off: block fills and stalls its input
				end
				1: begin
					send_gap_pct = 48;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 48;
				end
				default: begin
					send_gap_pct = 30;
					recv_stall_pct = 30;
				end
			endcase
			queued_bytes = 0;
			while (queued_bytes < 175) begin
				case ($urandom_range(19, 0))
					0: push_byte(8'($urandom()), 1'b0, $urandom());
					1: push_byte(8'($urandom()), 1'b1, $urandom());
					default: queue_random_dictionary();
				endcase
			end
			wait_for_drain();
		end

		repeat (8) @(posedge clk);
		if (awaited_results.size() != 0)
			log_failure($sformatf("%0d results never arrived", awaited_results.size()));
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> variant_metadata_dictionary_parser.f
hw/rtl/vmdp_pkg.sv
hw/rtl/vmdp_step.sv
hw/rtl/variant_metadata_dictionary_parser.sv
verif/tb.sv
